/* rtl/grc_pkg.sv */
// Shared types, constants and helpers for the graph reachability checker.
package grc_pkg;

    localparam int MAX_ENTRIES    = 64;
    localparam int MAX_SUCCESSORS = 8;

    localparam int ID_W      = 6;
    localparam int ID_SPACE  = 2 ** ID_W;
    localparam int CNT_OUT_W = 7;
    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int TOT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W     = $clog2(MAX_SUCCESSORS + 1);
    localparam int SUCC_DEPTH = MAX_ENTRIES * MAX_SUCCESSORS;
    localparam int SUCC_AW   = $clog2(SUCC_DEPTH);

    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_EDGE  = 3'd1;
    localparam logic [2:0] REQ_CHECK = 3'd2;
    localparam logic [2:0] REQ_QUERY = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0]      req_type;
        logic [ID_W-1:0] node_id;
        logic [ID_W-1:0] target_id;
        logic            error_mark;
    } t_req;

    typedef struct packed {
        logic                 status;
        logic [ID_W-1:0]      slot_index;
        logic [CNT_OUT_W-1:0] total_entries;
        logic [CNT_OUT_W-1:0] reachable_count;
        logic [CNT_OUT_W-1:0] error_count;
        logic [CNT_OUT_W-1:0] dead_end_count;
        logic                 property_ok;
        logic                 target_found;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic             err;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic cap;
        logic add_entry;
        logic clr_table;
        logic edge_write;
        logic idx_inc;
        logic walk_init;
        logic pop_rd;
        logic pop_take;
        logic ent_take;
        logic succ_take;
        logic fin_load;
    } t_cmd;

    typedef struct packed {
        logic       scan_end;
        logic       hit;
        logic       room;
        logic       depth_zero;
        logic       at_target;
        logic       succ_end;
        logic       out_free;
    } t_stat;

    function automatic logic [CNT_OUT_W-1:0] sat7(input logic [31:0] v);
        sat7 = (v > 32'd127) ? 7'd127 : v[CNT_OUT_W-1:0];
    endfunction

    function automatic logic [CNT_OUT_W-1:0] sat_inc7(input logic [CNT_OUT_W-1:0] v);
        sat_inc7 = (v == 7'd127) ? v : v + 7'd1;
    endfunction

endpackage

/* rtl/grc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/grc_dp.sv */
// Datapath: entry, successor and stack memories, walk bookkeeping, result register.
module grc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  grc_pkg::t_req     i_req,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_wdata,
    input  grc_pkg::t_cmd     i_cmd,
    output grc_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output grc_pkg::t_rsp     o_out_data
);

    localparam int ID_W  = grc_pkg::ID_W;
    localparam int IDX_W = grc_pkg::IDX_W;
    localparam int TOT_W = grc_pkg::TOT_W;
    localparam int CNT_W = grc_pkg::CNT_W;
    localparam int OW    = grc_pkg::CNT_OUT_W;
    localparam int SAW   = grc_pkg::SUCC_AW;

    grc_pkg::t_req   r_req;
    logic [ID_W-1:0] r_init;
    logic [TOT_W-1:0] r_total;
    logic [grc_pkg::ID_SPACE-1:0] r_present;
    logic [grc_pkg::ID_SPACE-1:0] r_visited;
    logic [TOT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_j;
    logic [CNT_W-1:0] r_cnt;
    logic [TOT_W-1:0] r_depth;
    logic [ID_W-1:0]  r_cur;
    logic             r_status;
    logic [ID_W-1:0]  r_slot;
    logic [OW-1:0]    r_reach;
    logic [OW-1:0]    r_errs;
    logic [OW-1:0]    r_dead;
    logic             r_found;
    logic             r_out_valid;
    grc_pkg::t_rsp    r_out;

    grc_pkg::t_entry  ent_rdata;
    grc_pkg::t_entry  ent_wdata;
    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr;
    logic [ID_W-1:0]  succ_rdata;
    logic [SAW-1:0]   succ_addr;
    logic [ID_W-1:0]  stk_rdata;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    logic [ID_W-1:0]  stk_wdata;
    logic [TOT_W-1:0] depth_m1;
    logic [ID_W-1:0]  walk_start;
    logic [ID_W-1:0]  key;
    logic             is_check;
    logic             is_query;
    logic             full;
    logic             push;
    logic             stk_room;
    grc_pkg::t_rsp    rsp;

    assign is_check   = (r_req.req_type == grc_pkg::REQ_CHECK);
    assign is_query   = (r_req.req_type == grc_pkg::REQ_QUERY);
    assign full       = (32'(r_total) >= 32'(grc_pkg::MAX_ENTRIES));
    assign walk_start = is_query ? r_req.node_id : r_init;
    assign key        = (r_req.req_type == grc_pkg::REQ_EDGE) ? r_req.node_id : r_cur;
    assign depth_m1   = r_depth - TOT_W'(1);
    assign stk_room   = (32'(r_depth) < 32'(grc_pkg::MAX_ENTRIES));
    assign succ_addr  = SAW'(r_idx[IDX_W-1:0] * grc_pkg::MAX_SUCCESSORS) + SAW'(r_j);
    // A successor is followed by a check only when its id is in the table.
    assign push = i_cmd.succ_take && (is_query || r_present[succ_rdata])
                  && !r_visited[succ_rdata];

    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = r_idx[IDX_W-1:0];
        ent_wdata = ent_rdata;
        if (i_cmd.add_entry) begin
            ent_we       = !full;
            ent_waddr    = r_total[IDX_W-1:0];
            ent_wdata.id  = r_req.node_id;
            ent_wdata.err = r_req.error_mark;
            ent_wdata.cnt = '0;
        end else if (i_cmd.edge_write) begin
            ent_we        = 1'b1;
            ent_wdata.cnt = ent_rdata.cnt + CNT_W'(1);
        end
    end

    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = r_depth[IDX_W-1:0];
        stk_wdata = succ_rdata;
        if (i_cmd.walk_init) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = walk_start;
        end else if (push) begin
            stk_we = stk_room;
        end
    end

    grc_ram #(.WIDTH($bits(grc_pkg::t_entry)), .DEPTH(grc_pkg::MAX_ENTRIES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ent_rdata)
    );

    grc_ram #(.WIDTH(ID_W), .DEPTH(grc_pkg::SUCC_DEPTH)) u_succ_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.edge_write),
        .i_waddr (SAW'(r_idx[IDX_W-1:0] * grc_pkg::MAX_SUCCESSORS) + SAW'(ent_rdata.cnt)),
        .i_wdata (r_req.target_id),
        .i_raddr (succ_addr),
        .o_rdata (succ_rdata)
    );

    grc_ram #(.WIDTH(ID_W), .DEPTH(grc_pkg::MAX_ENTRIES)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (depth_m1[IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        rsp                 = '0;
        rsp.status          = r_status;
        rsp.slot_index      = r_slot;
        rsp.target_found    = r_found;
        if (is_check) begin
            rsp.total_entries   = grc_pkg::sat7(32'(r_total));
            rsp.reachable_count = r_reach;
            rsp.error_count     = r_errs;
            rsp.dead_end_count  = r_dead;
            rsp.property_ok     = (r_errs == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= '0;
            r_total     <= '0;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_wdata;
            end
            if (i_cmd.clr_table) begin
                r_init    <= '0;
                r_total   <= '0;
                r_present <= '0;
            end
            if (i_cmd.add_entry && !full) begin
                r_total                   <= r_total + TOT_W'(1);
                r_present[r_req.node_id]  <= 1'b1;
            end
            if (i_cmd.fin_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req    <= i_req;
            r_status <= (i_req.req_type == grc_pkg::REQ_EDGE)
                        || (i_req.req_type > grc_pkg::REQ_CLEAR);
            r_slot   <= '0;
            r_reach  <= '0;
            r_errs   <= '0;
            r_dead   <= '0;
            r_found  <= 1'b0;
            r_idx    <= '0;
        end
        if (i_cmd.add_entry) begin
            r_status <= full;
            r_slot   <= full ? '0 : ID_W'(r_total);
        end
        if (i_cmd.edge_write) begin
            r_status <= 1'b0;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + TOT_W'(1);
        end
        if (i_cmd.walk_init) begin
            r_visited <= grc_pkg::ID_SPACE'(1) << walk_start;
            r_depth   <= TOT_W'(1);
        end
        if (i_cmd.pop_rd) begin
            r_depth <= depth_m1;
        end
        if (i_cmd.pop_take) begin
            r_cur   <= stk_rdata;
            r_reach <= grc_pkg::sat_inc7(r_reach);
            r_idx   <= '0;
            if (is_query && stk_rdata == r_req.target_id) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd.ent_take) begin
            r_cnt <= ent_rdata.cnt;
            r_j   <= '0;
            if (is_check && ent_rdata.err) begin
                r_errs <= grc_pkg::sat_inc7(r_errs);
            end
            if (is_check && ent_rdata.cnt == '0) begin
                r_dead <= grc_pkg::sat_inc7(r_dead);
            end
        end
        if (i_cmd.succ_take) begin
            r_j <= r_j + CNT_W'(1);
        end
        if (push) begin
            r_visited[succ_rdata] <= 1'b1;
            if (stk_room) begin
                r_depth <= r_depth + TOT_W'(1);
            end
        end
        if (i_cmd.fin_load) begin
            r_out <= rsp;
        end
    end

    assign o_stat.scan_end   = (r_idx == r_total);
    assign o_stat.hit        = (ent_rdata.id == key);
    assign o_stat.room       = (32'(ent_rdata.cnt) < 32'(grc_pkg::MAX_SUCCESSORS));
    assign o_stat.depth_zero = (r_depth == '0);
    assign o_stat.at_target  = is_query && (stk_rdata == r_req.target_id);
    assign o_stat.succ_end   = (r_j == r_cnt);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/grc_ctrl.sv */
// Controller: sequences table updates and the depth-first walk.
module grc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [2:0]     i_req_type,
    output logic           o_in_stall,
    input  grc_pkg::t_stat i_stat,
    output grc_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_CLR, S_E_RD, S_E_CHK, S_W_INIT, S_POP, S_POP2,
        S_SCAN, S_ECHK, S_SRD, S_SCHK, S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    priority if (i_req_type == grc_pkg::REQ_ADD) n_state = S_ADD;
                    else if (i_req_type == grc_pkg::REQ_EDGE) n_state = S_E_RD;
                    else if (i_req_type == grc_pkg::REQ_CHECK
                             || i_req_type == grc_pkg::REQ_QUERY) n_state = S_W_INIT;
                    else if (i_req_type == grc_pkg::REQ_CLEAR) n_state = S_CLR;
                    else n_state = S_FIN;
                end
            end
            S_ADD: begin
                o_cmd.add_entry = 1'b1;
                n_state = S_FIN;
            end
            S_CLR: begin
                o_cmd.clr_table = 1'b1;
                n_state = S_FIN;
            end
            S_E_RD: begin
                n_state = i_stat.scan_end ? S_FIN : S_E_CHK;
            end
            S_E_CHK: begin
                if (i_stat.hit && i_stat.room) begin
                    o_cmd.edge_write = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_E_RD;
                end
            end
            S_W_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                if (i_stat.depth_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.pop_rd = 1'b1;
                    n_state = S_POP2;
                end
            end
            S_POP2: begin
                o_cmd.pop_take = 1'b1;
                n_state = i_stat.at_target ? S_FIN : S_SCAN;
            end
            S_SCAN: begin
                n_state = i_stat.scan_end ? S_POP : S_ECHK;
            end
            S_ECHK: begin
                if (i_stat.hit) begin
                    o_cmd.ent_take = 1'b1;
                    n_state = S_SRD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SRD: begin
                if (i_stat.succ_end) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                o_cmd.succ_take = 1'b1;
                n_state = S_SRD;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/graph_reachability_checker_core.sv */
// Top level of the graph reachability checker: controller plus datapath.
//
//   channel  | beat signals              | payload
//   ---------+---------------------------+--------------------
//   request  | i_in_valid / o_in_stall   | i_in_data (t_req)
//   result   | o_out_valid / i_out_stall | o_out_data (t_rsp)
//   config   | i_cfg_we                  | i_cfg_wdata
//
// One request beat is worked at a time. Add entry and clear pass through their own state
// and then S_FIN, which loads the result; add edge reads and checks each table slot in
// turn until a slot with that id has room. A check or query pops ids from the stack and,
// per popped id, scans the table and reads the successors of each matching entry.
// Reset is synchronous and empties the table. The next request beat is taken
// while a result beat is still stalled; its result waits until the register frees.
module graph_reachability_checker_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  grc_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output grc_pkg::t_rsp o_out_data,
    input  logic          i_cfg_we,
    input  logic [5:0]    i_cfg_wdata
);

    grc_pkg::t_cmd  cmd;
    grc_pkg::t_stat stat;

    grc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    grc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/graph_reachability_checker_core_test.sv */
// Self-checking testbench for the graph reachability checker core.
`timescale 1ns / 1ps

module graph_reachability_checker_core_test;

    localparam int WATCHDOG_LIMIT = 400000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    grc_pkg::t_req in_data = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    grc_pkg::t_rsp out_data;
    logic          cfg_we = 1'b0;
    logic [5:0]    cfg_wdata = '0;

    graph_reachability_checker_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Shadow copy of the block's table.
    logic [5:0] tbl_id [grc_pkg::MAX_ENTRIES];
    logic       tbl_err [grc_pkg::MAX_ENTRIES];
    int         tbl_cnt [grc_pkg::MAX_ENTRIES];
    logic [5:0] tbl_succ [grc_pkg::MAX_ENTRIES][grc_pkg::MAX_SUCCESSORS];
    int         tbl_total = 0;
    logic [5:0] start_id = '0;

    grc_pkg::t_req pending_reqs[$];
    grc_pkg::t_rsp expected_rsps[$];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_off = 0;
    int   quiet_cycles = 0;
    bit   failed = 1'b0;

    function automatic bit id_present(logic [5:0] id);
        for (int k = 0; k < tbl_total; k++)
            if (tbl_id[k] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic grc_pkg::t_rsp predict_rsp(grc_pkg::t_req r);
        grc_pkg::t_rsp rsp;
        bit         seen [64];
        logic [5:0] stk [$];
        logic [5:0] cur;
        logic [5:0] nx;
        int         reach, errs, dead;
        bit         is_check;
        rsp = '0;
        reach = 0; errs = 0; dead = 0;
        case (r.req_type)
            grc_pkg::REQ_ADD: begin
                if (tbl_total >= grc_pkg::MAX_ENTRIES) begin
                    rsp.status = 1'b1;
                end else begin
                    tbl_id[tbl_total] = r.node_id;
                    tbl_err[tbl_total] = r.error_mark;
                    tbl_cnt[tbl_total] = 0;
                    rsp.slot_index = tbl_total[5:0];
                    tbl_total++;
                end
            end
            grc_pkg::REQ_EDGE: begin
                rsp.status = 1'b1;
                for (int i = 0; i < tbl_total; i++) begin
                    if (tbl_id[i] == r.node_id && tbl_cnt[i] < grc_pkg::MAX_SUCCESSORS) begin
                        tbl_succ[i][tbl_cnt[i]] = r.target_id;
                        tbl_cnt[i]++;
                        rsp.status = 1'b0;
                        break;
                    end
                end
            end
            grc_pkg::REQ_CHECK, grc_pkg::REQ_QUERY: begin
                is_check = (r.req_type == grc_pkg::REQ_CHECK);
                foreach (seen[k]) seen[k] = 1'b0;
                cur = is_check ? start_id : r.node_id;
                stk.push_back(cur);
                seen[cur] = 1'b1;
                while (stk.size() > 0) begin
                    cur = stk.pop_back();
                    reach++;
                    if (!is_check && cur == r.target_id) begin
                        rsp.target_found = 1'b1;
                        break;
                    end
                    for (int i = 0; i < tbl_total; i++) begin
                        if (tbl_id[i] != cur) continue;
                        if (tbl_err[i]) errs++;
                        if (tbl_cnt[i] == 0) dead++;
                        for (int j = 0; j < tbl_cnt[i]; j++) begin
                            nx = tbl_succ[i][j];
                            if ((!is_check || id_present(nx)) && !seen[nx]) begin
                                seen[nx] = 1'b1;
                                if (stk.size() < grc_pkg::MAX_ENTRIES) stk.push_back(nx);
                            end
                        end
                    end
                end
                if (is_check) begin
                    rsp.total_entries = grc_pkg::sat7(tbl_total);
                    rsp.reachable_count = grc_pkg::sat7(reach);
                    rsp.error_count = grc_pkg::sat7(errs);
                    rsp.dead_end_count = grc_pkg::sat7(dead);
                    rsp.property_ok = (errs == 0);
                end
            end
            grc_pkg::REQ_CLEAR: begin
                tbl_total = 0;
                start_id = '0;
            end
            default: rsp.status = 1'b1;
        endcase
        return rsp;
    endfunction

    // Driver: the predictor runs when a request beat is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_rsps.push_back(predict_rsp(in_data));
            end
            if (!in_valid || !in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    failed = 1'b1;
                end else begin
                    grc_pkg::t_rsp exp_rsp;
                    exp_rsp = expected_rsps.pop_front();
                    if (out_data !== exp_rsp) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_rsp,
                                 out_data);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("graph_reachability_checker_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic grc_pkg::t_req make_req(logic [2:0] kind, int node, int tgt, int err);
        grc_pkg::t_req r;
        r.req_type = kind;
        r.node_id = 6'(node);
        r.target_id = 6'(tgt);
        r.error_mark = 1'(err);
        return r;
    endfunction

    // Small random graph with a walk; ids drawn from a narrow range so edges hit.
    task automatic queue_graph(int n_ent, int n_edge, int span);
        pending_reqs.push_back(make_req(grc_pkg::REQ_CLEAR, $urandom, $urandom, $urandom));
        for (int k = 0; k < n_ent; k++)
            pending_reqs.push_back(make_req(grc_pkg::REQ_ADD, $urandom_range(span), $urandom,
                                            ($urandom_range(9) == 0)));
        for (int k = 0; k < n_edge; k++) begin
            if ($urandom_range(9) == 0)
                pending_reqs.push_back(make_req(3'($urandom_range(7)), $urandom, $urandom,
                                                $urandom));
            else
                pending_reqs.push_back(make_req(grc_pkg::REQ_EDGE, $urandom_range(span),
                                                $urandom_range(span), $urandom));
        end
        for (int k = 0; k < 3; k++)
            pending_reqs.push_back(make_req(grc_pkg::REQ_QUERY, $urandom_range(span),
                                            $urandom_range(span), $urandom));
        pending_reqs.push_back(make_req(grc_pkg::REQ_CHECK, $urandom, $urandom, $urandom));
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !in_valid && expected_rsps.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_start(logic [5:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        start_id = v;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty checks, extremes, full successor list.
        write_start(6'd63);
        pending_reqs.push_back(make_req(grc_pkg::REQ_CHECK, 0, 0, 0));
        pending_reqs.push_back(make_req(grc_pkg::REQ_QUERY, 63, 63, 1));
        pending_reqs.push_back(make_req(grc_pkg::REQ_QUERY, 0, 63, 0));
        pending_reqs.push_back(make_req(grc_pkg::REQ_EDGE, 5, 7, 0));
        pending_reqs.push_back(make_req(3'd5, 63, 63, 1));
        pending_reqs.push_back(make_req(3'd7, 0, 0, 0));
        pending_reqs.push_back(make_req(grc_pkg::REQ_ADD, 63, 0, 1));
        pending_reqs.push_back(make_req(grc_pkg::REQ_ADD, 63, 0, 0));
        for (int k = 0; k < 9; k++)
            pending_reqs.push_back(make_req(grc_pkg::REQ_EDGE, 63, k * 7, 0));
        pending_reqs.push_back(make_req(grc_pkg::REQ_CHECK, 0, 0, 0));
        pending_reqs.push_back(make_req(grc_pkg::REQ_QUERY, 63, 14, 0));
        pending_reqs.push_back(make_req(grc_pkg::REQ_CLEAR, 0, 0, 0));
        pending_reqs.push_back(make_req(grc_pkg::REQ_CHECK, 0, 0, 0));
        drain();

        // Fill the table past capacity with a chain, start at id 0.
        write_start(6'd0);
        for (int k = 0; k < 65; k++)
            pending_reqs.push_back(make_req(grc_pkg::REQ_ADD, k, 0, k & 1));
        for (int k = 0; k < 63; k++)
            pending_reqs.push_back(make_req(grc_pkg::REQ_EDGE, k, k + 1, 0));
        pending_reqs.push_back(make_req(grc_pkg::REQ_CHECK, 0, 0, 0));
        pending_reqs.push_back(make_req(grc_pkg::REQ_QUERY, 0, 63, 0));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 31 : 0;
            if (phase == 2) begin
                hold_off = 400;
                for (int k = 0; k < 40; k++)
                    pending_reqs.push_back(make_req(grc_pkg::REQ_ADD, $urandom, 0, $urandom));
            end
            for (int g = 0; g < 20; g++) begin
                int ent;
                ent = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
                queue_graph(ent, $urandom_range(ent * 2), $urandom_range(3, 63));
                if ($urandom_range(1)) begin
                    drain();
                    write_start((g == 0) ? 6'd63 : 6'($urandom_range(63)));
                end
            end
            drain();
        end

        if (!failed)
            $display("graph_reachability_checker_core regression: pass");
        else
            $display("graph_reachability_checker_core regression: fail");
        $finish;
    end
endmodule
